### design/double_ended_queue_top_assert.svh
// Assertion macros for the double-ended queue block.
// Included by the top level; it depends on nothing else.
`ifndef DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define DEQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("double-ended queue check failed");
// The consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("double-ended queue check failed");
`else
`define DEQ_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/deq_pkg.sv
// Shared widths and codes of the double-ended queue block.
// No dependencies; used by the top level.
package deq_pkg;

    // Field widths.
    localparam int CMD_W    = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REM_FRONT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REM_BACK  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

### design/deq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; instantiated by the double-ended queue top level.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data register holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/double_ended_queue_top.sv
// Top level of the double-ended queue: ring pointers, command sequencer and output register.
// Depends on deq_pkg, deq_ram and double_ended_queue_top_assert.svh.
//
// A double-ended queue of signed 32-bit words in a ring buffer of DEPTH entries, held in
// one synchronous RAM with a registered read. Inserts at either end, and any command that
// fails (insert when full, remove or dump when empty) or has an unused code, give their
// single result from the output register, and a new transaction can follow next, unless the
// output stalls. A remove passes through the streaming state, because the word comes out of
// the RAM in the cycle after the read is issued. A dump of N stored words issues one read to
// prime the RAM and then gives one word per cycle while the output does not stall, each cycle
// reading the next entry while the current word is loaded into the output register.
// Storage is not cleared after reset; only entries that were written are ever read.
`include "double_ended_queue_top_assert.svh"

module double_ended_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [deq_pkg::CMD_W-1:0]             i_command,
    input  logic signed [deq_pkg::WORD_W-1:0]     i_value,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [deq_pkg::WORD_W-1:0]     o_word,
    output logic [deq_pkg::STATUS_W-1:0]          o_status,
    output logic                                  o_last
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0]   DEPTH_S  = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] OCC_FULL = CW'(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_OUT
    } t_state;

    // Reduces a sum of two ring positions below twice DEPTH back into the ring.
    function automatic logic [IW-1:0] f_wrap(input logic [CW:0] sum);
        logic [CW:0] red;
        red = (sum >= DEPTH_S) ? sum - DEPTH_S : sum;
        return red[IW-1:0];
    endfunction

    t_state                        r_state, n_state;
    logic [IW-1:0]                 r_front, n_front;
    logic [CW-1:0]                 r_occ, n_occ;
    logic [IW-1:0]                 r_left, n_left;
    logic [IW-1:0]                 r_pos, n_pos;
    logic                          r_out_valid, n_out_valid;
    logic [deq_pkg::WORD_W-1:0]    r_out_word, n_out_word;
    logic [deq_pkg::STATUS_W-1:0]  r_out_status, n_out_status;
    logic                          r_out_last, n_out_last;

    logic                          ram_we;
    logic [IW-1:0]                 ram_waddr;
    logic                          ram_re;
    logic [IW-1:0]                 ram_raddr;
    logic [deq_pkg::WORD_W-1:0]    ram_rdata;

    logic                          out_free;
    logic                          in_accept;
    logic                          rem_take;
    logic [IW-1:0]                 front_dec;
    logic [IW-1:0]                 front_inc;
    logic [IW-1:0]                 back_slot;
    logic [IW-1:0]                 back_last;
    logic [IW-1:0]                 pos_inc;

    // Word store.
    deq_ram #(
        .WIDTH (deq_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (deq_pkg::WORD_W'($unsigned(i_value))),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Handshake: the output register can take a result when empty or being drained.
    assign out_free  = !r_out_valid || !i_stall;
    assign o_stall   = !((r_state == S_IDLE) && out_free);
    assign in_accept = i_valid && !o_stall;

    // A remove that finds a word to take.
    assign rem_take = in_accept && (r_occ != '0) &&
                      ((i_command == deq_pkg::CMD_REM_FRONT) ||
                       (i_command == deq_pkg::CMD_REM_BACK));

    // Ring positions around the front and back ends.
    assign front_dec = (r_front == '0) ? IW'(DEPTH - 1) : r_front - IW'(1);
    assign front_inc = f_wrap((CW + 1)'(r_front) + (CW + 1)'(1));
    assign back_slot = f_wrap((CW + 1)'(r_front) + (CW + 1)'(r_occ));
    assign back_last = f_wrap((CW + 1)'(r_front) + (CW + 1)'(r_occ - CW'(1)));
    assign pos_inc   = f_wrap((CW + 1)'(r_pos) + (CW + 1)'(1));

    // Command sequencer: decode in idle, then stream RAM words to the output register.
    always_comb begin
        n_state      = r_state;
        n_front      = r_front;
        n_occ        = r_occ;
        n_left       = r_left;
        n_pos        = r_pos;
        n_out_valid  = r_out_valid && i_stall;
        n_out_word   = r_out_word;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        ram_we       = 1'b0;
        ram_waddr    = back_slot;
        ram_re       = 1'b0;
        ram_raddr    = r_front;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_out_valid  = 1'b1;
                    n_out_word   = '0;
                    n_out_status = deq_pkg::ST_OK;
                    n_out_last   = 1'b1;
                    unique case (i_command) inside
                        deq_pkg::CMD_INS_FRONT, deq_pkg::CMD_INS_BACK: begin
                            if (r_occ == OCC_FULL) begin
                                n_out_status = deq_pkg::ST_FULL;
                            end else begin
                                ram_we = 1'b1;
                                if (i_command == deq_pkg::CMD_INS_FRONT) begin
                                    ram_waddr = front_dec;
                                    n_front   = front_dec;
                                end
                                n_occ = r_occ + CW'(1);
                            end
                        end
                        deq_pkg::CMD_REM_FRONT, deq_pkg::CMD_REM_BACK: begin
                            if (r_occ == '0) begin
                                n_out_status = deq_pkg::ST_EMPTY;
                            end else begin
                                n_out_valid = r_out_valid && i_stall;
                                ram_re      = 1'b1;
                                if (i_command == deq_pkg::CMD_REM_FRONT) begin
                                    n_front = front_inc;
                                end else begin
                                    ram_raddr = back_last;
                                end
                                n_pos   = ram_raddr;
                                n_left  = '0;
                                n_occ   = r_occ - CW'(1);
                                n_state = S_OUT;
                            end
                        end
                        deq_pkg::CMD_DUMP: begin
                            if (r_occ == '0) begin
                                n_out_status = deq_pkg::ST_EMPTY;
                            end else begin
                                n_out_valid = r_out_valid && i_stall;
                                ram_re      = 1'b1;
                                n_pos       = r_front;
                                n_left      = IW'(r_occ - CW'(1));
                                n_state     = S_OUT;
                            end
                        end
                        default: begin
                            // Unused codes give a plain ok result.
                        end
                    endcase
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_word   = ram_rdata;
                    n_out_status = deq_pkg::ST_OK;
                    n_out_last   = (r_left == '0);
                    if (r_left == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        // Fetch the next word while this one goes out.
                        ram_re    = 1'b1;
                        ram_raddr = pos_inc;
                        n_pos     = pos_inc;
                        n_left    = r_left - IW'(1);
                    end
                end
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        r_out_word   <= n_out_word;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
        r_left       <= n_left;
        r_pos        <= n_pos;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_word   = $signed(r_out_word);
    assign o_status = r_out_status;
    assign o_last   = r_out_last;

    // Occupancy never passes the ring size.
    `DEQ_ASSERT_SAME(a_occ_bound, i_clk, i_rst_n, 1'b1, r_occ <= OCC_FULL)
    // Words still to stream never exceed the stored words.
    `DEQ_ASSERT_SAME(a_left_bound, i_clk, i_rst_n, r_state == S_OUT, CW'(r_left) <= r_occ)
    // A result that is not the last of its command leaves the sequencer streaming.
    `DEQ_ASSERT_SAME(a_stream_open, i_clk, i_rst_n, r_out_valid && !r_out_last, r_state == S_OUT)
    // A remove from a non-empty store takes exactly one word.
    `DEQ_ASSERT_NEXT(a_rem_count, i_clk, i_rst_n, rem_take, r_occ == $past(r_occ) - CW'(1))

endmodule
